// ===== rtl/lcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// lcfe_pkg: shared constants and types of the lamp frame encoder
// Frame byte codes, sequencer step codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfe_pkg;

  localparam int LAMP_COUNT = 3;
  localparam int MAX_LAMPS  = 3;
  localparam int LAMPS      = (LAMP_COUNT < MAX_LAMPS) ? LAMP_COUNT : MAX_LAMPS;
  localparam int LAMP_W     = (LAMPS > 1) ? $clog2(LAMPS) : 1;

  localparam int SAMPLE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int COLOR_W  = 24;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W   = 4;

  // frame bytes
  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h5C;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_BYTE   = 8'h43;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h31;

  // position within one lamp frame
  localparam logic [STEP_W-1:0] ST_ESC0  = 4'd0;
  localparam logic [STEP_W-1:0] ST_START = 4'd1;
  localparam logic [STEP_W-1:0] ST_ID    = 4'd2;
  localparam logic [STEP_W-1:0] ST_CMD   = 4'd3;
  localparam logic [STEP_W-1:0] ST_RED   = 4'd4;
  localparam logic [STEP_W-1:0] ST_GRN   = 4'd5;
  localparam logic [STEP_W-1:0] ST_BLU   = 4'd6;
  localparam logic [STEP_W-1:0] ST_ESC1  = 4'd7;
  localparam logic [STEP_W-1:0] ST_END   = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ON_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_COLOR = 3'd4;

  // reset values
  localparam logic [MAX_LAMPS-1:0][BYTE_W-1:0] LAMP_ID_RST = {8'h2A, 8'h39, 8'h22};
  localparam logic [COLOR_W-1:0] ON_COLOR_RST  = 24'h00FF00;
  localparam logic [COLOR_W-1:0] OFF_COLOR_RST = 24'hFF0000;

  typedef logic [LAMPS-1:0][BYTE_W-1:0] lamp_ids_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamp;
    logic [STEP_W-1:0] step;
  } sel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              escape;
  } byte_info_t;

endpackage

`default_nettype wire

// ===== rtl/lcfe_byte_sel.sv =====
// ----------------------------------------------------------------------------
// lcfe_byte_sel: frame byte selector
// Picks the byte for the current lamp and step and flags bytes that are doubled.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfe_byte_sel (
  input  wire lcfe_pkg::sel_t              sel,
  input  wire logic [lcfe_pkg::LAMPS-1:0]  lamp_bits,
  input  wire lcfe_pkg::lamp_ids_t         lamp_ids,
  input  wire logic [lcfe_pkg::COLOR_W-1:0] on_color,
  input  wire logic [lcfe_pkg::COLOR_W-1:0] off_color,
  output lcfe_pkg::byte_info_t             info
);

  logic [lcfe_pkg::COLOR_W-1:0] color;
  logic [lcfe_pkg::BYTE_W-1:0]  value;
  logic                         escapable;

  assign color = lamp_bits[sel.lamp] ? on_color : off_color;

  always_comb begin
    value     = lcfe_pkg::ESC_BYTE;
    escapable = 1'b0;
    case (sel.step)
      lcfe_pkg::ST_ESC0:  value = lcfe_pkg::ESC_BYTE;
      lcfe_pkg::ST_START: value = lcfe_pkg::START_BYTE;
      lcfe_pkg::ST_ID: begin
        value     = lamp_ids[sel.lamp];
        escapable = 1'b1;
      end
      lcfe_pkg::ST_CMD:   value = lcfe_pkg::CMD_BYTE;
      lcfe_pkg::ST_RED: begin
        value     = color[23:16];
        escapable = 1'b1;
      end
      lcfe_pkg::ST_GRN: begin
        value     = color[15:8];
        escapable = 1'b1;
      end
      lcfe_pkg::ST_BLU: begin
        value     = color[7:0];
        escapable = 1'b1;
      end
      lcfe_pkg::ST_ESC1:  value = lcfe_pkg::ESC_BYTE;
      lcfe_pkg::ST_END:   value = lcfe_pkg::END_BYTE;
      default:            value = lcfe_pkg::ESC_BYTE;
    endcase
  end

  assign info.value  = value;
  assign info.escape = escapable && (value == lcfe_pkg::ESC_BYTE);

endmodule

`default_nettype wire

// ===== rtl/lcfe_seq.sv =====
// ----------------------------------------------------------------------------
// lcfe_seq: frame sequencer
// Walks lamps and frame steps, one byte per cycle into the output register while out_ready allows.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfe_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lcfe_pkg::LAMPS-1:0]    start_bits,
  input  wire lcfe_pkg::lamp_ids_t           lamp_ids,
  input  wire logic [lcfe_pkg::COLOR_W-1:0]  on_color,
  input  wire logic [lcfe_pkg::COLOR_W-1:0]  off_color,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lcfe_pkg::BYTE_W-1:0]        out_bus_byte,
  output logic                               out_frame_end
);

  logic                          busy_r, busy_nxt;
  logic [lcfe_pkg::LAMP_W-1:0]   lamp_r, lamp_nxt;
  logic [lcfe_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          dup_r, dup_nxt;
  logic [lcfe_pkg::LAMPS-1:0]    bits_r, bits_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [lcfe_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                          out_end_r, out_end_nxt;

  lcfe_pkg::sel_t       sel;
  lcfe_pkg::byte_info_t info;
  logic                 advance;
  logic                 last_byte;
  logic                 hold;

  assign sel.lamp = lamp_r;
  assign sel.step = step_r;

  lcfe_byte_sel u_byte_sel (
    .sel       (sel),
    .lamp_bits (bits_r),
    .lamp_ids  (lamp_ids),
    .on_color  (on_color),
    .off_color (off_color),
    .info      (info)
  );

  assign advance   = busy_r && (!out_valid_r || out_ready);
  // an escaped byte goes out twice before the step moves on
  assign hold      = info.escape && !dup_r;
  assign last_byte = !hold && (step_r == lcfe_pkg::ST_END) &&
                     (lamp_r == lcfe_pkg::LAMP_W'(lcfe_pkg::LAMPS - 1));

  always_comb begin
    busy_nxt      = busy_r;
    lamp_nxt      = lamp_r;
    step_nxt      = step_r;
    dup_nxt       = dup_r;
    bits_nxt      = bits_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      lamp_nxt = '0;
      step_nxt = lcfe_pkg::ST_ESC0;
      dup_nxt  = 1'b0;
      bits_nxt = start_bits;
    end else if (advance) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = info.value;
      out_end_nxt   = last_byte;
      if (hold) begin
        dup_nxt = 1'b1;
      end else begin
        dup_nxt = 1'b0;
        if (step_r == lcfe_pkg::ST_END) begin
          step_nxt = lcfe_pkg::ST_ESC0;
          lamp_nxt = lamp_r + lcfe_pkg::LAMP_W'(1);
        end else begin
          step_nxt = step_r + lcfe_pkg::STEP_W'(1);
        end
        if (last_byte) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      lamp_r      <= '0;
      step_r      <= lcfe_pkg::ST_ESC0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      lamp_r      <= lamp_nxt;
      step_r      <= step_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r     <= bits_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_bus_byte  = out_byte_r;
  assign out_frame_end = out_end_r;

endmodule

`default_nettype wire

// ===== rtl/input_change_lamp_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// input_change_lamp_frame_encoder_top: switch change to lamp frame encoder
// Emits one escaped command frame per lamp whenever the switch sample changes.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  input   | in_valid / in_ready   | in_switch_sample[2:0]
//  result  | out_valid / out_ready | out_bus_byte[7:0], out_frame_end
//  config  | cfg_we (no wait)      | cfg_index[2:0], cfg_data[23:0]
//
//  a changed sample gives 27 to 39 bytes, one per cycle unless out_ready stalls,
//  from the frame sequencer through the output register; in_ready is low while it runs
//  an unchanged or first sample is taken with no output
//  reset is synchronous, active low; config registers take their reset values
//  out_ready low freezes the sequencer while a byte is pending, with that byte held
// ----------------------------------------------------------------------------
`default_nettype none

module input_change_lamp_frame_encoder_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [lcfe_pkg::SAMPLE_W-1:0]    in_switch_sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [lcfe_pkg::BYTE_W-1:0]           out_bus_byte,
  output logic                                  out_frame_end,
  input  wire logic                             cfg_we,
  input  wire logic [lcfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lcfe_pkg::COLOR_W-1:0]     cfg_data
);

  lcfe_pkg::lamp_ids_t            lamp_ids_r, lamp_ids_nxt;
  logic [lcfe_pkg::COLOR_W-1:0]   on_color_r, on_color_nxt;
  logic [lcfe_pkg::COLOR_W-1:0]   off_color_r, off_color_nxt;
  logic [lcfe_pkg::SAMPLE_W-1:0]  prev_r, prev_nxt;
  logic                           seen_r, seen_nxt;

  logic in_xfer;
  logic start;
  logic busy;

  assign in_ready = !busy;
  assign in_xfer  = in_valid && in_ready;
  assign start    = in_xfer && seen_r && (in_switch_sample != prev_r);

  always_comb begin
    lamp_ids_nxt  = lamp_ids_r;
    on_color_nxt  = on_color_r;
    off_color_nxt = off_color_r;
    if (cfg_we) begin
      for (int i = 0; i < lcfe_pkg::LAMPS; i++) begin
        if (cfg_index == lcfe_pkg::CFG_IDX_W'(i)) begin
          lamp_ids_nxt[i] = cfg_data[lcfe_pkg::BYTE_W-1:0];
        end
      end
      if (cfg_index == lcfe_pkg::REG_ON_COLOR) begin
        on_color_nxt = cfg_data;
      end
      if (cfg_index == lcfe_pkg::REG_OFF_COLOR) begin
        off_color_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    if (in_xfer) begin
      prev_nxt = in_switch_sample;
      seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcfe_pkg::LAMPS; i++) begin
        lamp_ids_r[i] <= lcfe_pkg::LAMP_ID_RST[i];
      end
      on_color_r  <= lcfe_pkg::ON_COLOR_RST;
      off_color_r <= lcfe_pkg::OFF_COLOR_RST;
      prev_r      <= '0;
      seen_r      <= 1'b0;
    end else begin
      lamp_ids_r  <= lamp_ids_nxt;
      on_color_r  <= on_color_nxt;
      off_color_r <= off_color_nxt;
      prev_r      <= prev_nxt;
      seen_r      <= seen_nxt;
    end
  end

  lcfe_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .start_bits    (in_switch_sample[lcfe_pkg::LAMPS-1:0]),
    .lamp_ids      (lamp_ids_r),
    .on_color      (on_color_r),
    .off_color     (off_color_r),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bus_byte  (out_bus_byte),
    .out_frame_end (out_frame_end)
  );

  // the run ends exactly when its closing byte is loaded
  a_end_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_frame_end))
    else $error("sequencer finished without a closing byte");

  // a run always closes on the frame end byte
  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_bus_byte == lcfe_pkg::END_BYTE))
    else $error("frame end flag on a byte other than the end code");

  // an unchanged or first sample starts no run
  a_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !start) |=> !busy)
    else $error("sequencer started on an unchanged sample");

endmodule

`default_nettype wire
